>>> rtl/xrrg_pkg.sv
// Package for the xoshiro random range generator: widths, mixing constants,
// register map, request kinds and the sequencer state type.
// No dependencies.
package xrrg_pkg;

   localparam int WORD_W  = 64;
   localparam int VALUE_W = 32;
   localparam int ADDR_W  = 4;

   // SplitMix64 constants used when a seed is expanded into generator state.
   localparam logic [WORD_W-1:0] MIX_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] MIX_MUL1  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL2  = 64'h94d0_49bb_1331_11eb;
   localparam int MIX_SHIFT1 = 30;
   localparam int MIX_SHIFT2 = 27;
   localparam int MIX_SHIFT3 = 31;

   // xoshiro256** shift and rotate amounts.
   localparam int XS_SHIFT   = 17;
   localparam int XS_ROT     = 45;
   localparam int XS_OUT_ROT = 7;

   // Register index of the seed register (byte address bit 3 selects it).
   localparam logic CSR_SEED = 1'b0;

   // Request kinds.
   localparam logic KIND_RAW    = 1'b0;
   localparam logic KIND_RANGED = 1'b1;

   typedef enum logic [3:0] {
      S_MIX_ADD,
      S_MIX_MUL1,
      S_MIX_WAIT1,
      S_MIX_MUL2,
      S_MIX_WAIT2,
      S_IDLE,
      S_THRESH,
      S_THRESH_WAIT,
      S_DRAW,
      S_DRAW_OUT,
      S_CHECK,
      S_MOD,
      S_MOD_WAIT,
      S_RESULT
   } state_type;

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned k);
      rotl64 = (x << k) | (x >> (WORD_W - k));
   endfunction

endpackage

>>> rtl/xoshiro_random_range_generator_unit.sv
// Top level of the xoshiro random range generator: sequencer, state words,
// seed register and output register. Depends on xrrg_pkg, xrrg_mul64 and
// xrrg_mod32.
//
// Usage. A request transaction on the req_ channel carries req_kind and
// req_range; it is taken when req_valid is high and req_stall is low. Each
// request yields exactly one response transaction on the rsp_ channel with
// rsp_value. A raw request returns the upper 32 bits of one xoshiro256**
// draw. A ranged request returns an unbiased value below req_range, drawing
// again while the draw is below 2^32 mod range; a range of zero returns zero
// and leaves the generator untouched.
// Timing. One request is handled at a time and req_stall stays high meanwhile. A
// ranged request runs the bit-serial remainder unit twice (threshold, then final
// reduction), and each redraw repeats the draw and the check.
// Reset and seeding. After reset, and after every write of the 64-bit seed
// register at byte address 0, the four state words are reloaded from four
// SplitMix64 outputs of the seed. The reload is built around a shared iterative
// 64-bit multiplier, and req_stall stays high until it finishes. The user must make
// seed writes only while the block is idle; the block itself does not enforce this.
// Back-pressure. A finished response waits in the output register while
// rsp_stall is high; the next request can already be accepted meanwhile, and
// its result is held back until the output register is free.
module xoshiro_random_range_generator_unit (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [xrrg_pkg::VALUE_W-1:0]  req_range,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [xrrg_pkg::VALUE_W-1:0]  rsp_value,
   // Register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [xrrg_pkg::ADDR_W-1:0]   paddr,
   input  logic [xrrg_pkg::WORD_W-1:0]   pwdata,
   output logic [xrrg_pkg::WORD_W-1:0]   prdata,
   output logic                          pready
);
   import xrrg_pkg::*;

   state_type           state_ff, state_in;
   logic [WORD_W-1:0]   gen_ff [4];
   logic [WORD_W-1:0]   gen_in [4];
   logic [WORD_W-1:0]   seed_ff, seed_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]   z_ff, z_in;
   logic [1:0]          idx_ff, idx_in;
   logic                kind_ff, kind_in;
   logic [VALUE_W-1:0]  range_ff, range_in;
   logic [VALUE_W-1:0]  thresh_ff, thresh_in;
   logic [WORD_W-1:0]   t_ff, t_in;
   logic [VALUE_W-1:0]  draw_ff, draw_in;
   logic [VALUE_W-1:0]  result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                req_take;
   logic                seed_write;
   logic                out_free;

   logic                mul_start;
   logic [WORD_W-1:0]   mul_a;
   logic [WORD_W-1:0]   mul_b;
   logic                mul_done;
   logic [WORD_W-1:0]   mul_product;
   logic                mod_start;
   logic [VALUE_W-1:0]  mod_dividend;
   logic                mod_done;
   logic [VALUE_W-1:0]  mod_rem;

   logic [WORD_W-1:0]   mix_out;
   logic [WORD_W-1:0]   draw_sum;
   logic [WORD_W-1:0]   nx0, nx1, nx2, nx3;

   assign req_take   = req_valid && !req_stall;
   assign seed_write = psel && penable && pwrite && pready && (paddr[3] == CSR_SEED);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Final SplitMix64 fold of the second product.
   assign mix_out = mul_product ^ (mul_product >> MIX_SHIFT3);

   // xoshiro256** state transition, from the current words.
   assign nx2 = gen_ff[2] ^ gen_ff[0] ^ (gen_ff[1] << XS_SHIFT);
   assign nx1 = gen_ff[1] ^ gen_ff[2] ^ gen_ff[0];
   assign nx0 = gen_ff[0] ^ gen_ff[3] ^ gen_ff[1];
   assign nx3 = rotl64(gen_ff[3] ^ gen_ff[1], XS_ROT);

   // Second half of the scrambler: t * 9.
   assign draw_sum = t_ff + (t_ff << 3);

   xrrg_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   xrrg_mod32 u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (range_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_MIX_ADD:   state_in = S_MIX_MUL1;
         S_MIX_MUL1:  state_in = S_MIX_WAIT1;
         S_MIX_WAIT1: if (mul_done) state_in = S_MIX_MUL2;
         S_MIX_MUL2:  state_in = S_MIX_WAIT2;
         S_MIX_WAIT2: begin
            if (mul_done) begin
               state_in = (idx_ff == 2'd3) ? S_IDLE : S_MIX_ADD;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_RAW) begin
                  state_in = S_DRAW;
               end else if (req_range == '0) begin
                  state_in = S_RESULT;
               end else begin
                  state_in = S_THRESH;
               end
            end
         end
         S_THRESH:      state_in = S_THRESH_WAIT;
         S_THRESH_WAIT: if (mod_done) state_in = S_DRAW;
         S_DRAW:        state_in = S_DRAW_OUT;
         S_DRAW_OUT:    state_in = (kind_ff == KIND_RAW) ? S_RESULT : S_CHECK;
         S_CHECK:       state_in = (draw_ff >= thresh_ff) ? S_MOD : S_DRAW;
         S_MOD:         state_in = S_MOD_WAIT;
         S_MOD_WAIT:    if (mod_done) state_in = S_RESULT;
         S_RESULT:      if (out_free) state_in = S_IDLE;
         default:       state_in = S_IDLE;
      endcase
      // A seed write restarts the expansion.
      if (seed_write) begin
         state_in = S_MIX_ADD;
      end
   end

   // Sequencer outputs: handshake and shared unit control.
   always_comb begin
      req_stall    = 1'b1;
      mul_start    = 1'b0;
      mul_a        = acc_ff ^ (acc_ff >> MIX_SHIFT1);
      mul_b        = MIX_MUL1;
      mod_start    = 1'b0;
      mod_dividend = draw_ff;
      unique case (state_ff)
         S_IDLE:     req_stall = 1'b0;
         S_MIX_MUL1: mul_start = 1'b1;
         S_MIX_MUL2: begin
            mul_start = 1'b1;
            mul_a     = z_ff ^ (z_ff >> MIX_SHIFT2);
            mul_b     = MIX_MUL2;
         end
         S_THRESH: begin
            mod_start    = 1'b1;
            mod_dividend = '0 - range_ff;
         end
         S_MOD:      mod_start = 1'b1;
         default:    req_stall = 1'b1;
      endcase
   end

   // Datapath registers.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         gen_in[i] = gen_ff[i];
      end
      seed_in      = seed_ff;
      acc_in       = acc_ff;
      z_in         = z_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      range_in     = range_ff;
      thresh_in    = thresh_ff;
      t_in         = t_ff;
      draw_in      = draw_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         S_MIX_ADD: acc_in = acc_ff + MIX_GAMMA;
         S_MIX_WAIT1: begin
            if (mul_done) z_in = mul_product;
         end
         S_MIX_WAIT2: begin
            if (mul_done) begin
               gen_in[idx_ff] = mix_out;
               idx_in         = idx_ff + 2'd1;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               kind_in   = req_kind;
               range_in  = req_range;
               result_in = '0;
            end
         end
         S_THRESH_WAIT: begin
            if (mod_done) thresh_in = mod_rem;
         end
         S_DRAW: begin
            t_in      = rotl64(gen_ff[1] + (gen_ff[1] << 2), XS_OUT_ROT);
            gen_in[0] = nx0;
            gen_in[1] = nx1;
            gen_in[2] = nx2;
            gen_in[3] = nx3;
         end
         S_DRAW_OUT: begin
            draw_in   = draw_sum[WORD_W-1:VALUE_W];
            result_in = draw_sum[WORD_W-1:VALUE_W];
         end
         S_MOD_WAIT: begin
            if (mod_done) result_in = mod_rem;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
            end
         end
         default: ;
      endcase

      if (seed_write) begin
         seed_in = pwdata;
         acc_in  = pwdata;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_MIX_ADD;
         seed_ff      <= '0;
         acc_ff       <= '0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         acc_ff       <= acc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int i = 0; i < 4; i++) begin
         gen_ff[i] <= gen_in[i];
      end
      z_ff         <= z_in;
      kind_ff      <= kind_in;
      range_ff     <= range_in;
      thresh_ff    <= thresh_in;
      t_ff         <= t_in;
      draw_ff      <= draw_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[3] == CSR_SEED) ? seed_ff : '0;

   // The multiplier only reports completion while the expansion waits for it.
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MIX_WAIT1 || state_ff == S_MIX_WAIT2))
      else $error("multiplier completed outside a wait state");

   // The remainder unit only reports completion while the sequencer waits.
   a_mod_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_THRESH_WAIT || state_ff == S_MOD_WAIT))
      else $error("remainder unit completed outside a wait state");

   // The final reduction always lands below the requested range.
   a_mod_below_range: assert property (@(posedge clock) disable iff (reset)
      (mod_done && state_ff == S_MOD_WAIT) |-> (mod_rem < range_ff))
      else $error("ranged result not below range");

   // A ranged request with a zero range goes straight to a zero result.
   a_zero_range: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_kind == KIND_RANGED && req_range == '0 && !seed_write)
      |=> (state_ff == S_RESULT && result_ff == '0))
      else $error("zero range request did not give zero");

endmodule

>>> rtl/xrrg_mul64.sv
// Iterative 64 x 64 multiplier giving the low 64 bits of the product.
// Uses one 32 x 32 multiplier. Depends on xrrg_pkg.
module xrrg_mul64 (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [xrrg_pkg::WORD_W-1:0]  op_a,
   input  logic [xrrg_pkg::WORD_W-1:0]  op_b,
   output logic                         done,
   output logic [xrrg_pkg::WORD_W-1:0]  product
);
   import xrrg_pkg::*;

   localparam int HALF_W = WORD_W / 2;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   b_ff, b_in;
   logic [WORD_W-1:0]   prod_ff, prod_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [HALF_W-1:0]   mul_x;
   logic [HALF_W-1:0]   mul_y;

   // Partial products: low x low, low x high, high x low. The high x high
   // term falls entirely above bit 63.
   always_comb begin
      case (cnt_ff)
         2'd1: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[WORD_W-1:HALF_W];
         end
         2'd2: begin
            mul_x = a_ff[WORD_W-1:HALF_W];
            mul_y = b_ff[HALF_W-1:0];
         end
         default: begin
            mul_x = a_ff[HALF_W-1:0];
            mul_y = b_ff[HALF_W-1:0];
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         prod_in = WORD_W'(mul_x) * WORD_W'(mul_y);
         cnt_in  = cnt_ff + 2'd1;
         case (cnt_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            default: acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         endcase
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> rtl/xrrg_mod32.sv
// Restoring remainder unit: 32-bit dividend modulo a non-zero 32-bit divisor,
// one quotient bit per cycle. Depends on xrrg_pkg.
module xrrg_mod32 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [xrrg_pkg::VALUE_W-1:0]  dividend,
   input  logic [xrrg_pkg::VALUE_W-1:0]  divisor,
   output logic                          done,
   output logic [xrrg_pkg::VALUE_W-1:0]  remainder
);
   import xrrg_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  dvd_ff, dvd_in;
   logic [VALUE_W-1:0]  dvs_ff, dvs_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W:0]    trial;
   logic [VALUE_W:0]    diff;

   assign trial = {rem_ff, dvd_ff[VALUE_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[VALUE_W-1:0];
         end else begin
            rem_in = trial[VALUE_W-1:0];
         end
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for xoshiro_random_range_generator_unit: a directed table and
// random requests under several seeds, checked against a predictor. Needs xrrg_pkg and the RTL.
module tb_top;
   import xrrg_pkg::*;

   // Byte address bit 3 picks the register. The seed lives at 0, and address 8 maps to no
   // register, so a write there must leave the generator alone.
   localparam logic [ADDR_W-1:0] SEED_ADDR  = {CSR_SEED, 3'b000};
   localparam logic [ADDR_W-1:0] SPARE_ADDR = {~CSR_SEED, 3'b000};

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 147;
   localparam int DIRECTED_COUNT  = 18;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_HOLD} stall_mode_type;

   // One row of the directed table. Where pinned is set, the expected value is written
   // into the table. Every other row is checked against the predictor.
   typedef struct packed {
      logic        kind;
      logic [31:0] bound;
      logic        pinned;
      logic [31:0] pinned_value;
   } request_row_type;

   localparam request_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{KIND_RAW,    32'h0000_0000, 1'b0, 32'h0},
      '{KIND_RAW,    32'hffff_ffff, 1'b0, 32'h0},   // the bound means nothing to a raw draw
      '{KIND_RANGED, 32'h0000_0000, 1'b1, 32'h0},   // zero bound: zero, generator untouched
      '{KIND_RANGED, 32'h0000_0001, 1'b1, 32'h0},   // bound of one: one draw, result zero
      '{KIND_RANGED, 32'h0000_0002, 1'b0, 32'h0},
      '{KIND_RANGED, 32'h0000_0003, 1'b0, 32'h0},
      '{KIND_RANGED, 32'hffff_ffff, 1'b0, 32'h0},
      '{KIND_RANGED, 32'hffff_fffe, 1'b0, 32'h0},
      '{KIND_RANGED, 32'h8000_0000, 1'b0, 32'h0},
      '{KIND_RANGED, 32'h8000_0001, 1'b0, 32'h0},   // close to half of all draws are rejected
      '{KIND_RANGED, 32'h7fff_ffff, 1'b0, 32'h0},
      '{KIND_RANGED, 32'hc000_0001, 1'b0, 32'h0},
      '{KIND_RANGED, 32'h0000_0000, 1'b1, 32'h0},
      '{KIND_RAW,    32'h5555_5555, 1'b0, 32'h0},
      '{KIND_RANGED, 32'haaaa_aaaa, 1'b0, 32'h0},
      '{KIND_RANGED, 32'h0000_0001, 1'b1, 32'h0},
      '{KIND_RANGED, 32'h0000_000a, 1'b0, 32'h0},
      '{KIND_RAW,    32'h0000_0000, 1'b0, 32'h0}
   };

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind  = KIND_RAW;
   logic [VALUE_W-1:0]  req_range = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_value;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [ADDR_W-1:0]   paddr     = '0;
   logic [WORD_W-1:0]   pwdata    = '0;
   logic [WORD_W-1:0]   prdata;
   logic                pready;

   // The predictor's copy of the seed register and of the four generator words.
   logic [WORD_W-1:0]   seed_shadow;
   logic [WORD_W-1:0]   gen_word [4];

   // Values still owed by the block, oldest first.
   logic [VALUE_W-1:0]  expected_values [$];

   int burst_left    = 0;
   int stall_left    = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int raw_sent      = 0;
   int ranged_sent   = 0;
   int checked_count = 0;
   int error_count   = 0;

   xoshiro_random_range_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_range (req_range),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit: several times what the slowest correct run needs.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // SplitMix64 expansion: the generator words become the first four outputs of the
   // sequence that starts at the seed.
   task automatic load_generator(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] z;
      acc = s;
      for (int i = 0; i < 4; i++) begin
         acc = acc + MIX_GAMMA;
         z = acc;
         z = (z ^ (z >> MIX_SHIFT1)) * MIX_MUL1;
         z = (z ^ (z >> MIX_SHIFT2)) * MIX_MUL2;
         gen_word[i] = z ^ (z >> MIX_SHIFT3);
      end
   endtask

   // One xoshiro256** step. It returns the upper half of the scrambled output.
   function automatic logic [VALUE_W-1:0] draw_upper();
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] scrambled;
      logic [WORD_W-1:0] shifted;
      t = gen_word[1] * 64'd5;
      t = {t[56:0], t[63:57]};                  // rotate left by 7
      scrambled = t * 64'd9;
      shifted = gen_word[1] << 17;
      gen_word[2] = gen_word[2] ^ gen_word[0];
      gen_word[3] = gen_word[3] ^ gen_word[1];
      gen_word[1] = gen_word[1] ^ gen_word[2];
      gen_word[0] = gen_word[0] ^ gen_word[3];
      gen_word[2] = gen_word[2] ^ shifted;
      gen_word[3] = {gen_word[3][18:0], gen_word[3][63:19]};   // rotate left by 45
      return scrambled[63:32];
   endfunction

   // Value owed for one request. A ranged draw is rejected while it lies below
   // 2^32 mod bound, so that the remainder that is kept is unbiased.
   function automatic logic [VALUE_W-1:0] predict_value(input logic kind,
                                                        input logic [VALUE_W-1:0] bound);
      logic [VALUE_W-1:0] floor_value;
      logic [VALUE_W-1:0] r;
      if (kind == KIND_RAW)
         return draw_upper();
      if (bound == '0)
         return '0;
      floor_value = (32'd0 - bound) % bound;
      do
         r = draw_upper();
      while (r < floor_value);
      return r % bound;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // A write has a setup cycle and an access cycle. The task then waits with psel low, so
   // that the next transfer never drives psel in the same time step.
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == SEED_ADDR) begin
         seed_shadow = data;
         load_generator(data);
      end
      @(posedge clock);
   endtask

   task automatic check_seed_readback();
      logic [WORD_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= SEED_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== seed_shadow)
         report_mismatch($sformatf("seed read back %h, written %h", got, seed_shadow));
      @(posedge clock);
   endtask

   // Offers one request transaction and holds it until it is taken. Requests come in
   // bursts. A gap of idle cycles opens at the end of each burst, and now and then a
   // long burst runs with no gap at all.
   task automatic issue_request(input logic kind, input logic [VALUE_W-1:0] bound,
                                input logic pinned, input logic [VALUE_W-1:0] pinned_value);
      logic [VALUE_W-1:0] predicted;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_range <= bound;
      do @(posedge clock); while (req_stall);
      predicted = predict_value(kind, bound);
      expected_values.push_back(pinned ? pinned_value : predicted);
      if (kind == KIND_RAW)
         raw_sent++;
      else
         ranged_sent++;
   endtask

   // Lowers valid and waits until every value owed has come back. Every request gives
   // a result, so the block is idle at that point. A short pause follows for safety.
   task automatic drain_block();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_values.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Bounds are mostly skewed towards the awkward cases: tiny bounds, powers of two, and
   // bounds just above 2^31, where rejection is frequent.
   function automatic logic [VALUE_W-1:0] pick_bound();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom_range(1, 16);
         2: return 32'd1 << $urandom_range(0, 31);
         3: return 32'hffff_ffff - $urandom_range(0, 15);
         4: return 32'h8000_0000 + $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // The receiver has its own pattern: runs of no stall, coin-flip stalls, sparse stalls
   // and solid holds, each lasting a random number of cycles.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
         default:      rsp_stall <= 1'b1;
      endcase
   end

   // Each response transaction is compared with the oldest value still owed.
   always @(posedge clock) begin : check_responses
      logic [VALUE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing outstanding", rsp_value));
         end else begin
            want = expected_values.pop_front();
            checked_count++;
            if (rsp_value !== want)
               report_mismatch($sformatf("value %h, expected %h", rsp_value, want));
         end
      end
   end

   initial begin
      logic [WORD_W-1:0] seeds [PHASES];
      request_row_type row;
      seeds[0] = 64'hffff_ffff_ffff_ffff;
      seeds[1] = 64'h0;
      seeds[2] = {$urandom, $urandom};
      seeds[3] = 64'h8000_0000_0000_0000;
      seeds[4] = 64'h1;
      seeds[5] = {$urandom, $urandom};

      // Reset loads the generator from a seed of zero.
      seed_shadow = '0;
      load_generator('0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_seed_readback();

      // Directed table, run from the reset state of the generator.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         issue_request(row.kind, row.bound, row.pinned, row.pinned_value);
      end
      drain_block();

      // Random phases. Each phase reseeds first. Every other phase also writes the
      // unmapped address, which must not disturb the generator.
      for (int p = 0; p < PHASES; p++) begin
         csr_write(SEED_ADDR, seeds[p]);
         if (p % 2 == 1)
            csr_write(SPARE_ADDR, {$urandom, $urandom});
         check_seed_readback();
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            issue_request(1'($urandom_range(0, 1)), pick_bound(), 1'b0, '0);
         drain_block();
      end

      repeat (100) @(posedge clock);
      $display("Run covered %0d raw and %0d ranged requests over %0d seeds plus reset;",
               raw_sent, ranged_sent, PHASES);
      $display("%0d responses were compared, with %0d mismatches.", checked_count, error_count);
      if (error_count == 0 && expected_values.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
